// File: rtl/rv32ie_pkg.sv
// ----------------------------------------------------------------------------
// rv32ie_pkg
// shared types, opcodes and constants of the i-type execute unit
// ----------------------------------------------------------------------------
package rv32ie_pkg;

  localparam int unsigned CSR_DEPTH_DEF    = 4096;
  localparam int unsigned MEPC_ADDRESS_DEF = 833;
  localparam int unsigned NUM_REGS         = 32;
  localparam int unsigned XLEN             = 32;

  typedef enum logic [4:0] {
    OP_ADDI   = 5'd0,
    OP_XORI   = 5'd1,
    OP_ORI    = 5'd2,
    OP_ANDI   = 5'd3,
    OP_SLLI   = 5'd4,
    OP_SRLI   = 5'd5,
    OP_SRAI   = 5'd6,
    OP_SLTI   = 5'd7,
    OP_SLTIU  = 5'd8,
    OP_JALR   = 5'd9,
    OP_SYSTEM = 5'd10,
    OP_CSRRW  = 5'd11,
    OP_CSRRS  = 5'd12,
    OP_CSRRC  = 5'd13,
    OP_CSRRWI = 5'd14,
    OP_CSRRSI = 5'd15,
    OP_CSRRCI = 5'd16
  } opcode_t;

  localparam logic [11:0] F12_ECALL  = 12'h000;
  localparam logic [11:0] F12_EBREAK = 12'h001;
  localparam logic [11:0] F12_MRET   = 12'h302;
  localparam logic [11:0] F12_WFI    = 12'h105;

  localparam logic [3:0] CAUSE_NONE    = 4'd0;
  localparam logic [3:0] CAUSE_ILLEGAL = 4'd2;
  localparam logic [3:0] CAUSE_EBREAK  = 4'd3;
  localparam logic [3:0] CAUSE_ECALL   = 4'd11;

  typedef struct packed {
    logic [4:0]         opcode;
    logic [4:0]         dest_index;
    logic [4:0]         src_index;
    logic signed [11:0] immediate;
    logic [11:0]        csr_address;
    logic [31:0]        pc;
    logic [31:0]        instr_word;
  } exe_in_t;

  typedef struct packed {
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic [31:0] next_pc;
    logic        trap_raised;
    logic [3:0]  trap_cause;
    logic [31:0] trap_value;
  } exe_out_t;

  typedef struct packed {
    logic        we;
    logic [31:0] wdata;
  } csr_wr_t;

endpackage

// File: rtl/rv32ie_in_if.sv
// ----------------------------------------------------------------------------
// rv32ie_in_if
// instruction channel: valid/ready handshake with a decoded i-type payload
// ----------------------------------------------------------------------------
interface rv32ie_in_if;
  import rv32ie_pkg::*;

  logic    valid;
  logic    ready;
  exe_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/rv32ie_out_if.sv
// ----------------------------------------------------------------------------
// rv32ie_out_if
// result channel: valid/ready handshake with write-back, next pc and trap
// ----------------------------------------------------------------------------
interface rv32ie_out_if;
  import rv32ie_pkg::*;

  logic     valid;
  logic     ready;
  exe_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/rv32ie_ram.sv
// ----------------------------------------------------------------------------
// rv32ie_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rv32ie_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/rv32ie_alu.sv
// ----------------------------------------------------------------------------
// rv32ie_alu
// execute logic: immediate alu, jalr, csr read-modify-write and system ops
// ----------------------------------------------------------------------------
module rv32ie_alu (
  input  rv32ie_pkg::exe_in_t  item,
  input  logic [31:0]          src_val,
  input  logic [31:0]          csr_old,
  output rv32ie_pkg::exe_out_t res,
  output rv32ie_pkg::csr_wr_t  csr_wr
);
  import rv32ie_pkg::*;

  logic [31:0] imm32;
  logic [4:0]  sh;
  logic [31:0] zimm;
  logic [31:0] pc_plus4;
  logic        wr;
  logic [31:0] val;

  assign imm32    = {{20{item.immediate[11]}}, item.immediate};
  assign sh       = item.immediate[4:0];
  assign zimm     = {27'd0, sh};
  assign pc_plus4 = item.pc + 32'd4;

  always_comb begin
    wr                = 1'b0;
    val               = '0;
    res               = '0;
    res.next_pc       = pc_plus4;
    res.trap_cause    = CAUSE_NONE;
    csr_wr            = '0;
    unique case (opcode_t'(item.opcode))
      OP_ADDI:  begin wr = 1'b1; val = src_val + imm32; end
      OP_XORI:  begin wr = 1'b1; val = src_val ^ imm32; end
      OP_ORI:   begin wr = 1'b1; val = src_val | imm32; end
      OP_ANDI:  begin wr = 1'b1; val = src_val & imm32; end
      OP_SLLI:  begin wr = 1'b1; val = src_val << sh; end
      OP_SRLI:  begin wr = 1'b1; val = src_val >> sh; end
      OP_SRAI:  begin wr = 1'b1; val = 32'($signed(src_val) >>> sh); end
      OP_SLTI:  begin wr = 1'b1; val = {31'd0, $signed(src_val) < $signed(imm32)}; end
      OP_SLTIU: begin wr = 1'b1; val = {31'd0, src_val < imm32}; end
      OP_JALR: begin
        wr          = 1'b1;
        val         = pc_plus4;
        res.next_pc = (src_val + imm32) & ~32'd1;
      end
      OP_SYSTEM: begin
        priority if (item.immediate == F12_ECALL) begin
          res.trap_raised = 1'b1;
          res.trap_cause  = CAUSE_ECALL;
        end else if (item.immediate == F12_EBREAK) begin
          res.trap_raised = 1'b1;
          res.trap_cause  = CAUSE_EBREAK;
        end else if (item.immediate == F12_MRET) begin
          res.next_pc = csr_old;
        end else if (item.immediate == F12_WFI) begin
          res.next_pc = pc_plus4;
        end else begin
          res.trap_raised = 1'b1;
          res.trap_cause  = CAUSE_ILLEGAL;
          res.trap_value  = item.instr_word;
        end
      end
      OP_CSRRW: begin
        wr     = 1'b1;
        val    = csr_old;
        csr_wr = '{we: 1'b1, wdata: src_val};
      end
      OP_CSRRS: begin
        wr     = 1'b1;
        val    = csr_old;
        csr_wr = '{we: item.src_index != 5'd0, wdata: csr_old | src_val};
      end
      OP_CSRRC: begin
        wr     = 1'b1;
        val    = csr_old;
        csr_wr = '{we: item.src_index != 5'd0, wdata: csr_old & ~src_val};
      end
      OP_CSRRWI: begin
        wr     = 1'b1;
        val    = csr_old;
        csr_wr = '{we: 1'b1, wdata: zimm};
      end
      OP_CSRRSI: begin
        wr     = 1'b1;
        val    = csr_old;
        csr_wr = '{we: sh != 5'd0, wdata: csr_old | zimm};
      end
      OP_CSRRCI: begin
        wr     = 1'b1;
        val    = csr_old;
        csr_wr = '{we: sh != 5'd0, wdata: csr_old & ~zimm};
      end
      default: begin
        res.trap_raised = 1'b1;
        res.trap_cause  = CAUSE_ILLEGAL;
        res.trap_value  = item.instr_word;
      end
    endcase
    res.reg_write = wr && (item.dest_index != 5'd0);
    res.reg_index = res.reg_write ? item.dest_index : 5'd0;
    res.reg_value = res.reg_write ? val : 32'd0;
  end

endmodule

// File: rtl/rv32i_itype_execute_unit_top.sv
// ----------------------------------------------------------------------------
// rv32i_itype_execute_unit_top
// executes decoded rv32i i-type instructions against a register file and
// a csr store, one result transaction per instruction transaction
// ----------------------------------------------------------------------------
// usage:
//   in_if  : decoded instruction (opcode, rd, rs1, immediate, csr number,
//            pc, raw word), valid/ready handshake
//   out_if : register write-back, next pc and trap report, valid/ready
//   flow   : the instruction is registered with its ram reads on accept,
//            the result in the output register; no new instruction is
//            taken until the last leaves execute, set by the read-then-write
//            access of both rams (read in the accept cycle, write at commit)
//   reset  : the register file is cleared at once through per-entry valid
//            bits; the csr ram is cleared by a pass over all CSR_DEPTH
//            entries (4096 by default) during which in_if.ready stays low
//   stall  : the result waits in an output register, and the next
//            instruction is accepted meanwhile; it then holds in execute,
//            without touching either ram, until that register frees
// ----------------------------------------------------------------------------
module rv32i_itype_execute_unit_top #(
  parameter int unsigned CSR_DEPTH    = rv32ie_pkg::CSR_DEPTH_DEF,
  parameter int unsigned MEPC_ADDRESS = rv32ie_pkg::MEPC_ADDRESS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rv32ie_in_if.sink    in_if,
  rv32ie_out_if.source out_if
);
  import rv32ie_pkg::*;

  localparam int unsigned CSR_AW = (CSR_DEPTH > 1) ? $clog2(CSR_DEPTH) : 1;
  localparam int unsigned RF_AW  = $clog2(NUM_REGS);
  localparam logic [CSR_AW-1:0] MEPC_IDX  = CSR_AW'(MEPC_ADDRESS);
  localparam logic [CSR_AW-1:0] CLR_LAST  = CSR_AW'(CSR_DEPTH - 1);
  localparam logic              MEPC_OK   = (MEPC_ADDRESS < CSR_DEPTH);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [CSR_AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic                clr_last;
  exe_in_t             item_r;
  logic                csr_ok_r;
  logic [CSR_AW-1:0]   csr_idx_r;
  logic [NUM_REGS-1:0] rf_vld_r;
  logic                out_valid_r;
  exe_out_t            out_data_r;

  logic                in_acc;
  logic                out_free;
  logic                commit;
  logic                is_sys;
  logic                csr_ok_in;
  logic [CSR_AW-1:0]   csr_raddr;

  logic [XLEN-1:0]     rf_rdata;
  logic [XLEN-1:0]     csr_rdata;
  logic [XLEN-1:0]     src_val;
  logic [XLEN-1:0]     csr_old;
  exe_out_t            alu_res;
  csr_wr_t             alu_csr;

  logic                rf_we;
  logic                csr_we;
  logic [CSR_AW-1:0]   csr_waddr;
  logic [XLEN-1:0]     csr_wdata;

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;
  assign commit      = (state_r == ST_EXEC) && out_free;
  assign clr_last    = (clr_cnt_r == CLR_LAST);

  // mret reads mepc through the same csr read port
  assign is_sys    = (in_if.data.opcode == OP_SYSTEM);
  assign csr_raddr = is_sys ? MEPC_IDX : in_if.data.csr_address[CSR_AW-1:0];
  assign csr_ok_in = is_sys ? MEPC_OK : (32'(in_if.data.csr_address) < CSR_DEPTH);

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r    <= in_if.data;
      csr_ok_r  <= csr_ok_in;
      csr_idx_r <= in_if.data.csr_address[CSR_AW-1:0];
    end
  end

  // register file: entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (rf_we) begin
      rf_vld_r[item_r.dest_index] <= 1'b1;
    end
  end

  assign rf_we = commit && alu_res.reg_write;

  rv32ie_ram #(
    .WIDTH (XLEN),
    .DEPTH (NUM_REGS)
  ) u_rf_ram (
    .clk   (clk),
    .we    (rf_we),
    .waddr (item_r.dest_index[RF_AW-1:0]),
    .wdata (alu_res.reg_value),
    .re    (in_acc),
    .raddr (in_if.data.src_index[RF_AW-1:0]),
    .rdata (rf_rdata)
  );

  assign csr_we    = (state_r == ST_CLEAR) || (commit && alu_csr.we && csr_ok_r);
  assign csr_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : csr_idx_r;
  assign csr_wdata = (state_r == ST_CLEAR) ? '0 : alu_csr.wdata;

  rv32ie_ram #(
    .WIDTH (XLEN),
    .DEPTH (CSR_DEPTH)
  ) u_csr_ram (
    .clk   (clk),
    .we    (csr_we),
    .waddr (csr_waddr),
    .wdata (csr_wdata),
    .re    (in_acc),
    .raddr (csr_raddr),
    .rdata (csr_rdata)
  );

  assign src_val = (item_r.src_index != 5'd0 && rf_vld_r[item_r.src_index]) ? rf_rdata : '0;
  assign csr_old = csr_ok_r ? csr_rdata : '0;

  rv32ie_alu u_alu (
    .item    (item_r),
    .src_val (src_val),
    .csr_old (csr_old),
    .res     (alu_res),
    .csr_wr  (alu_csr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= alu_res;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  // x0 is never written
  a_rf_no_x0: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |-> item_r.dest_index != 5'd0)
    else $error("register file write to x0");

  // rams are only written back when the result register can take the result
  a_wb_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    (rf_we || (csr_we && state_r != ST_CLEAR)) |-> commit)
    else $error("write back without result commit");

  // a trapping instruction changes no state
  a_trap_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && alu_res.trap_raised) |-> !rf_we && !csr_we)
    else $error("trapping instruction wrote state");

  // a new result appears only right after an execute cycle
  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EXEC))
    else $error("result without execute");

  // the clearing pass runs to its end before any instruction is taken
  a_clear_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && !clr_last) |=> state_r == ST_CLEAR)
    else $error("csr clearing pass cut short");

endmodule
